// ===== rtl/core/tpls_pkg.sv =====
// Shared types and constants for the two-page log store.
`timescale 1ns / 1ps
package tpls_pkg;
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam logic [1:0] PS_ACTIVE    = 2'd0;
  localparam logic [1:0] PS_RECEIVING = 2'd1;
  localparam logic [1:0] PS_CLEAR     = 2'h3;

  typedef enum logic [3:0] {
    CMD_NONE,       // hold
    CMD_LOAD,       // latch input item, clear found flag
    CMD_SCAN_INIT,  // set scan pointer to newest slot of a page
    CMD_SCAN_STEP,  // compare read data, step pointer back
    CMD_APPEND,     // write record at fill index
    CMD_MOVE_FIRST, // write new record at slot 0 of other page
    CMD_NEXT_KEY,   // advance copy key
    CMD_COPY,       // copy found record to other page
    CMD_ERASE,      // erase one slot of old page
    CMD_SWAP,       // make other page active
    CMD_RESULT      // latch result
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic key_ok;
    logic same;
    logic page_full;
    logic copy_key_last;
    logic copy_skip;
    logic erase_done;
    logic is_write;
  } dp_status_t;
endpackage

// ===== rtl/core/tpls_if.sv =====
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface tpls_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tpls_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tpls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/tpls_datapath.sv =====
// Datapath: record memory, scan pointer, fill count and result registers.
`timescale 1ns / 1ps
module tpls_datapath import tpls_pkg::*; #(
  parameter int SLOTS = 255,
  parameter int KEY_WIDTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  input  logic       in_opcode,
  input  logic [7:0] in_key,
  input  logic [15:0] in_write_value,
  output dp_status_t st,
  output logic [15:0] res_value,
  output logic        res_status,
  output logic [7:0]  res_free
);
  localparam int DEPTH = 2 * SLOTS;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(SLOTS + 1);
  localparam int KW = (SW > 8) ? SW : 8;
  localparam logic [31:0] KMASK = (32'd1 << KEY_WIDTH) - 32'd1;
  localparam logic [31:0] VMASK = (32'd1 << VALUE_WIDTH) - 32'd1;

  logic        op_r;
  logic [KW-1:0] key_r, ckey_r;
  logic [31:0] wval_r, val_r;
  logic        found_r, pg_r, scanpg_r, scanning_r;
  logic        rdv_r, copying_r;
  logic [SW-1:0] ptr_r, fill_r, n_r;
  logic [1:0]  ps_r [2];
  logic [15:0] rv_r; logic rs_r; logic [7:0] rf_r;
  logic        we; logic [AW-1:0] addr; logic [31:0] wdata, rdata;
  logic [KW-1:0] skey;
  logic        hit;

  tpls_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  function automatic logic kvalid(input logic [KW-1:0] k);
    return (32'(k) < 32'(SLOTS)) && (32'(k) < KMASK);
  endfunction

  // scan key: copy key during transfer, item key otherwise
  assign skey = copying_r ? ckey_r : key_r;
  assign hit = (rdata & KMASK) == (32'(skey) & KMASK);

  always_comb begin
    we = 1'b0; wdata = 32'hFFFF_FFFF;
    addr = AW'(32'(scanpg_r) * SLOTS + 32'(ptr_r));
    case (cmd)
      CMD_APPEND: begin
        we = 1'b1; addr = AW'(32'(pg_r) * SLOTS + 32'(fill_r));
        wdata = ((wval_r & VMASK) << KEY_WIDTH) | (32'(key_r) & KMASK);
      end
      CMD_MOVE_FIRST: begin
        we = 1'b1; addr = AW'(32'(!pg_r) * SLOTS);
        wdata = ((wval_r & VMASK) << KEY_WIDTH) | (32'(key_r) & KMASK);
      end
      CMD_COPY: begin
        we = 1'b1; addr = AW'(32'(!pg_r) * SLOTS + 32'(n_r));
        wdata = ((val_r & VMASK) << KEY_WIDTH) | (32'(ckey_r) & KMASK);
      end
      CMD_ERASE: begin
        we = 1'b1; addr = AW'(32'(pg_r) * SLOTS + 32'(ptr_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_r <= 1'b0; fill_r <= '0; ps_r[0] <= PS_ACTIVE; ps_r[1] <= PS_CLEAR;
      scanning_r <= 1'b0; rdv_r <= 1'b0; copying_r <= 1'b0;
    end else begin
      // read data is valid in the cycle after a scan step issued a live address
      rdv_r <= (cmd == CMD_SCAN_STEP) && scanning_r;
      case (cmd)
        CMD_LOAD: begin
          op_r <= in_opcode; key_r <= KW'(in_key);
          wval_r <= 32'(in_write_value) & VMASK; found_r <= 1'b0;
          scanpg_r <= pg_r; copying_r <= 1'b0;
        end
        CMD_SCAN_INIT: begin
          // start at the newest written slot; an empty page has nothing to scan
          ptr_r <= fill_r - 1'b1; found_r <= 1'b0; scanning_r <= (fill_r != '0);
        end
        CMD_SCAN_STEP: begin
          // read data belongs to the address issued last cycle
          if (rdv_r && !found_r && hit) begin
            found_r <= 1'b1; val_r <= (rdata >> KEY_WIDTH) & VMASK;
          end
          if (ptr_r != '0) ptr_r <= ptr_r - 1'b1;
          else scanning_r <= 1'b0;
        end
        CMD_APPEND: fill_r <= fill_r + 1'b1;
        CMD_MOVE_FIRST: begin
          ps_r[!pg_r] <= PS_RECEIVING; n_r <= SW'(1); ckey_r <= '0;
          scanpg_r <= pg_r; copying_r <= 1'b1;
        end
        CMD_NEXT_KEY: ckey_r <= ckey_r + 1'b1;
        CMD_COPY: n_r <= n_r + 1'b1;
        CMD_ERASE: if (ptr_r != '0) ptr_r <= ptr_r - 1'b1;
        CMD_SWAP: begin
          ps_r[pg_r] <= PS_CLEAR; ps_r[!pg_r] <= PS_ACTIVE;
          pg_r <= !pg_r; fill_r <= n_r;
        end
        CMD_RESULT: begin
          rv_r <= (op_r == OP_READ && found_r && kvalid(key_r)) ? 16'(val_r) : '0;
          rs_r <= (op_r == OP_READ) && !(found_r && kvalid(key_r));
          rf_r <= (32'(SLOTS) - 32'(fill_r) > 32'd255) ? 8'hFF :
                  8'(32'(SLOTS) - 32'(fill_r));
        end
        default: ;
      endcase
    end
  end

  assign st.scan_done  = !scanning_r;
  assign st.found      = found_r;
  assign st.key_ok     = kvalid(key_r);
  assign st.same       = found_r && (val_r == wval_r);
  assign st.page_full  = 32'(fill_r) >= 32'(SLOTS);
  assign st.copy_key_last = 32'(ckey_r) >= 32'(SLOTS - 1);
  assign st.copy_skip  = (ckey_r == key_r) || !kvalid(ckey_r) || 32'(n_r) >= 32'(SLOTS);
  assign st.erase_done = ptr_r == '0;
  assign st.is_write   = op_r == OP_WRITE;
  assign res_value = rv_r; assign res_status = rs_r; assign res_free = rf_r;
  logic unused;
  assign unused = ^{ps_r[0], ps_r[1]};
endmodule

// ===== rtl/core/tpls_ctrl.sv =====
// Controller state machine for lookup, append and page transfer.
`timescale 1ns / 1ps
module tpls_ctrl import tpls_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_DRAIN, S_DECIDE, S_MOVE, S_CINIT, S_CSCAN, S_CDRAIN,
    S_CDEC, S_NEXTK, S_EINIT, S_ERASE, S_SWAP, S_RES, S_OUT
  } state_t;
  state_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r; ov_nxt = ov_r; cmd = CMD_NONE;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin cmd = CMD_LOAD; state_nxt = S_INIT; end
      S_INIT: begin cmd = CMD_SCAN_INIT; state_nxt = S_SCAN; end
      // one slot read a cycle, newest first; data arrives in the following cycle
      S_SCAN: begin cmd = CMD_SCAN_STEP; if (st.scan_done) state_nxt = S_DRAIN; end
      S_DRAIN: state_nxt = st.is_write ? S_DECIDE : S_RES;
      S_DECIDE:
        if (!st.key_ok || st.same) state_nxt = S_RES;
        else if (!st.page_full) begin cmd = CMD_APPEND; state_nxt = S_RES; end
        else state_nxt = S_MOVE;
      S_MOVE: begin cmd = CMD_MOVE_FIRST; state_nxt = S_CDEC; end
      S_CDEC: if (st.copy_skip) state_nxt = S_CDRAIN; else state_nxt = S_CINIT;
      S_CINIT: begin cmd = CMD_SCAN_INIT; state_nxt = S_CSCAN; end
      S_CSCAN: begin cmd = CMD_SCAN_STEP; if (st.scan_done) state_nxt = S_CDRAIN; end
      S_CDRAIN: begin
        if (!st.copy_skip && st.found) cmd = CMD_COPY;
        if (st.copy_key_last) state_nxt = S_EINIT;
        else state_nxt = S_NEXTK;
      end
      S_NEXTK: begin cmd = CMD_NEXT_KEY; state_nxt = S_CDEC; end
      S_EINIT: begin cmd = CMD_SCAN_INIT; state_nxt = S_ERASE; end
      S_ERASE: begin cmd = CMD_ERASE; if (st.erase_done) state_nxt = S_SWAP; end
      S_SWAP: begin cmd = CMD_SWAP; state_nxt = S_RES; end
      S_RES: begin cmd = CMD_RESULT; state_nxt = S_OUT; end
      S_OUT: if (!ov_r) begin ov_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin state_r <= S_IDLE; ov_r <= 1'b0; end
    else begin state_r <= state_nxt; ov_r <= ov_nxt; end
  end
endmodule

// ===== rtl/core/two_page_log_store_core.sv =====
// Top level of the two-page log store.
// Input channel (in_*): opcode, key, write_value. Read returns the newest
// value of key; write appends a record unless the key is invalid or the
// value is unchanged. Output channel (out_*): read_value, status,
// free_slots, one item per input. The scan reads one slot a cycle, newest
// first, over the written slots of the active page (at most SLOTS), from
// the single-port record RAM. One item at a time: the next input is taken
// at the earliest in the cycle after the result leaves.
// A write into a full page runs a transfer:
// each key is looked up in the old page, then the old page is erased one
// slot a cycle.
// Reset: page 0 active and empty; the record RAM is not cleared, the fill
// count bounds the live slots of a page and a transfer erases the old page.
// A stalled receiver holds the result; the next item is not taken until the
// result register is free.
`timescale 1ns / 1ps
module two_page_log_store_core import tpls_pkg::*; #(
  parameter int SLOTS = 255,
  parameter int KEY_WIDTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input logic clk,
  input logic rst_n,
  tpls_if.sink   in_ch,
  tpls_if.source out_ch
);
  dp_cmd_t cmd;
  dp_status_t st;
  logic [15:0] rv; logic rs; logic [7:0] rf;

  tpls_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .st(st), .cmd(cmd));

  tpls_datapath #(.SLOTS(SLOTS), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_opcode(in_ch.data[24]), .in_key(in_ch.data[23:16]),
    .in_write_value(in_ch.data[15:0]), .st(st),
    .res_value(rv), .res_status(rs), .res_free(rf));

  // payload packing: {read_value, status, free_slots}
  assign out_ch.data = {rv, rs, rf};
endmodule

// ===== test/two_page_log_store_core_test.sv =====
// Self-checking testbench for the two-page log store core.
`timescale 1ns / 1ps
module two_page_log_store_core_test import tpls_pkg::*;;

  localparam int SLOTS = 255;
  localparam int KEY_WIDTH = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int IN_W = 1 + 8 + 16;
  localparam int OUT_W = 16 + 1 + 8;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 2 * SLOTS * (SLOTS + 8);
  localparam longint CYCLE_LIMIT = 6000000;
  localparam logic [31:0] ERASED = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  key;
    logic [15:0] write_value;
  } request_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        status;
    logic [7:0]  free_slots;
  } response_t;

  logic clk;
  logic rst_n;

  tpls_if #(.W(IN_W))  in_ch ();
  tpls_if #(.W(OUT_W)) out_ch ();

  two_page_log_store_core #(
    .SLOTS(SLOTS),
    .KEY_WIDTH(KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of both flash pages and the page bookkeeping.
  logic [31:0] flash_image [0:2*SLOTS-1];
  logic        live_page;
  int          used_slots;

  request_t  pending_requests[$];
  response_t expected_responses[$];
  int        failures = 0;
  int        sent_count = 0;
  int        driven_count = 0;
  longint    cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic key_usable(logic [7:0] key);
    return (key < SLOTS) && (key < ((1 << KEY_WIDTH) - 1));
  endfunction

  // Scan a page from its newest slot back; the first matching key wins.
  function automatic logic lookup_newest(logic pg, logic [15:0] key, output logic [15:0] val);
    int base;
    base = pg * SLOTS;
    val = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (flash_image[base + i][15:0] == key) begin
        val = flash_image[base + i][31:16];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Move the new record plus the newest copy of every other usable key to the
  // other page, erase the old one and switch pages.
  function automatic void transfer_page(logic [7:0] key, logic [15:0] val);
    logic        old_pg;
    logic        new_pg;
    int          n;
    logic [15:0] v;
    old_pg = live_page;
    new_pg = ~live_page;
    n = 0;
    flash_image[new_pg * SLOTS] = {val, 8'h00, key};
    n++;
    for (int k = 0; k < SLOTS; k++) begin
      if (k == key || !key_usable(k[7:0])) continue;
      if (lookup_newest(old_pg, k[15:0], v) && n < SLOTS) begin
        flash_image[new_pg * SLOTS + n] = {v, k[15:0]};
        n++;
      end
    end
    for (int i = 0; i < SLOTS; i++) flash_image[old_pg * SLOTS + i] = ERASED;
    live_page = new_pg;
    used_slots = n;
  endfunction

  function automatic response_t apply_request(request_t req);
    response_t   rsp;
    logic [15:0] v;
    logic        hit;
    int          left;
    rsp = '0;
    if (req.opcode == OP_READ) begin
      if (key_usable(req.key) && lookup_newest(live_page, {8'h00, req.key}, v)) begin
        rsp.read_value = v;
      end else begin
        rsp.status = 1'b1;
      end
    end else if (key_usable(req.key)) begin
      hit = lookup_newest(live_page, {8'h00, req.key}, v);
      // Skip the write when the stored value is already equal.
      if (!(hit && v == req.write_value)) begin
        if (used_slots < SLOTS) begin
          flash_image[live_page * SLOTS + used_slots] = {req.write_value, 8'h00, req.key};
          used_slots++;
        end else begin
          transfer_page(req.key, req.write_value);
        end
      end
    end
    left = SLOTS - used_slots;
    rsp.free_slots = (left > 255) ? 8'd255 : left[7:0];
    return rsp;
  endfunction

  function automatic request_t make_request(logic op, logic [7:0] key, logic [15:0] val);
    request_t r;
    r.opcode = op;
    r.key = key;
    r.write_value = val;
    return r;
  endfunction

  // Pick idle probability (percent) by phase: none, sender, receiver, both.
  function automatic int sender_idle_pct();
    case ((sent_count / 150) % 4)
      1: begin
        return 47;
      end
      3: begin
        return 15;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((sent_count / 150) % 4)
      2: begin
        return 47;
      end
      3: begin
        return 15;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  // Drive the request channel and the receiver ready on the falling edge; hold an item until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());
      // Present the next item once the current one has been taken.
      if (!in_ch.valid || sent_count == driven_count) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_requests[0];
          driven_count <= driven_count + 1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Sample both handshakes on the rising edge.
  always @(posedge clk) begin
    response_t got;
    response_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_responses.push_back(apply_request(pending_requests.pop_front()));
      sent_count <= sent_count + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected item %h", $time, got);
        failures++;
      end else begin
        want = expected_responses.pop_front();
        if (got.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   want.read_value, got.read_value);
          failures++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, got.status);
          failures++;
        end
        if (got.free_slots !== want.free_slots) begin
          $display("%0t: free_slots expected %0d actual %0d", $time,
                   want.free_slots, got.free_slots);
          failures++;
        end
      end
    end
  end

  initial begin
    logic [7:0]  key;
    logic [15:0] val;
    int          pick;
    for (int i = 0; i < 2 * SLOTS; i++) flash_image[i] = ERASED;
    live_page = 1'b0;
    used_slots = 0;

    // Directed: empty reads, field extremes, invalid keys, equal-value writes.
    pending_requests.push_back(make_request(OP_READ, 8'd0, 16'h0000));
    pending_requests.push_back(make_request(OP_READ, 8'd254, 16'hFFFF));
    pending_requests.push_back(make_request(OP_WRITE, 8'd0, 16'h0000));
    pending_requests.push_back(make_request(OP_READ, 8'd0, 16'h0000));
    pending_requests.push_back(make_request(OP_WRITE, 8'd254, 16'hFFFF));
    pending_requests.push_back(make_request(OP_READ, 8'd254, 16'h0000));
    pending_requests.push_back(make_request(OP_WRITE, 8'd254, 16'hFFFF));
    pending_requests.push_back(make_request(OP_WRITE, 8'd0, 16'h0000));
    pending_requests.push_back(make_request(OP_WRITE, 8'd255, 16'h1234));
    pending_requests.push_back(make_request(OP_READ, 8'd255, 16'hFFFF));
    pending_requests.push_back(make_request(OP_WRITE, 8'd170, 16'hAAAA));
    pending_requests.push_back(make_request(OP_WRITE, 8'd85, 16'h5555));
    pending_requests.push_back(make_request(OP_WRITE, 8'd170, 16'h5555));
    pending_requests.push_back(make_request(OP_READ, 8'd170, 16'h0000));
    pending_requests.push_back(make_request(OP_READ, 8'd85, 16'h0000));
    pending_requests.push_back(make_request(OP_READ, 8'd1, 16'h0000));

    // Random: mostly a small key set so reads hit and the page fills and
    // transfers; some wide keys and invalid keys as noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) key = 8'($urandom_range(15));
      else if (pick < 95) key = 8'($urandom_range(254));
      else key = 8'd255;
      pick = $urandom_range(99);
      if (pick < 20) val = 16'($urandom_range(3));
      else val = 16'($urandom);
      pending_requests.push_back(make_request($urandom_range(99) < 60, key, val));
    end

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_requests.size() > 0) @(posedge clk);
    while (expected_responses.size() > 0) @(posedge clk);
    for (int i = 0; i < DRAIN_CYCLES && !out_ch.valid; i++) @(posedge clk);
    repeat (2) @(posedge clk);

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== two_page_log_store_core.f =====
rtl/core/tpls_pkg.sv
rtl/core/tpls_if.sv
rtl/core/tpls_ram.sv
rtl/core/tpls_datapath.sv
rtl/core/tpls_ctrl.sv
rtl/core/two_page_log_store_core.sv
test/two_page_log_store_core_test.sv
